// ----- rtl/aes_rnd_pkg.sv -----
// Shared constants and byte-level functions for the AES encryption round.
// Holds the S-box table, the field doubling used by MixColumns and the word widths.
// No dependencies; imported by aes_rnd_core and aes_encrypt_round.
`default_nettype none

package aes_rnd_pkg;

  // Each 128-bit value is carried as two halves of this width.
  localparam int HALF_W  = 64;
  localparam int BYTE_W  = 8;
  localparam int NBYTES  = 16;

  // Reduction polynomial x^8 + x^4 + x^3 + x + 1, less its top bit.
  localparam logic [BYTE_W-1:0] GF_POLY = 8'h1b;

  // Forward AES substitution table, entry 0 first.
  localparam logic [BYTE_W-1:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // SubBytes for a single byte.
  function automatic logic [BYTE_W-1:0] sub_byte(input logic [BYTE_W-1:0] b);
    return SBOX[b];
  endfunction

  // Multiplication by x in GF(2^8).
  function automatic logic [BYTE_W-1:0] xtime(input logic [BYTE_W-1:0] b);
    return {b[BYTE_W-2:0], 1'b0} ^ (b[BYTE_W-1] ? GF_POLY : '0);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/aes_rnd_core.sv -----
// Combinational datapath of one AES encryption round.
// SubBytes, ShiftRows, MixColumns and AddRoundKey on a 128-bit state.
// Depends on aes_rnd_pkg for the S-box and field doubling.
`default_nettype none

module aes_rnd_core (
  input  wire logic [aes_rnd_pkg::HALF_W-1:0] state_low,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0] state_high,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0] key_low,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0] key_high,
  output logic      [aes_rnd_pkg::HALF_W-1:0] res_low,
  output logic      [aes_rnd_pkg::HALF_W-1:0] res_high
);
  import aes_rnd_pkg::*;

  logic [2*HALF_W-1:0] state_w;
  logic [2*HALF_W-1:0] key_w;
  logic [2*HALF_W-1:0] res_w;
  logic [BYTE_W-1:0]   sub_b [NBYTES];
  logic [BYTE_W-1:0]   mix_b [NBYTES];

  assign state_w = {state_high, state_low};
  assign key_w   = {key_high, key_low};

  // SubBytes and ShiftRows: row r of column c is taken from column (c + r) mod 4.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sub_b[4*c + r] = sub_byte(state_w[BYTE_W*(4*((c + r) % 4) + r) +: BYTE_W]);
      end
    end
  end

  // MixColumns, written as a ^ (sum of column) ^ 2(a ^ next) for each row.
  always_comb begin
    logic [BYTE_W-1:0] all_x;
    for (int c = 0; c < 4; c++) begin
      all_x = sub_b[4*c] ^ sub_b[4*c + 1] ^ sub_b[4*c + 2] ^ sub_b[4*c + 3];
      for (int r = 0; r < 4; r++) begin
        mix_b[4*c + r] = sub_b[4*c + r] ^ all_x
                       ^ xtime(sub_b[4*c + r] ^ sub_b[4*c + ((r + 1) % 4)]);
      end
    end
  end

  // AddRoundKey and packing back into the two halves.
  always_comb begin
    for (int i = 0; i < NBYTES; i++) begin
      res_w[BYTE_W*i +: BYTE_W] = mix_b[i] ^ key_w[BYTE_W*i +: BYTE_W];
    end
  end

  assign res_low  = res_w[HALF_W-1:0];
  assign res_high = res_w[2*HALF_W-1:HALF_W];

endmodule

`default_nettype wire

// ----- rtl/aes_encrypt_round.sv -----
// Top level of the AES encryption round: input register, round logic, result register.
// Depends on aes_rnd_pkg and aes_rnd_core.
`default_nettype none

// One AES encryption round (SubBytes, ShiftRows, MixColumns, AddRoundKey) per
// transfer. An item is taken on every clock edge at which start is high; busy is
// never raised, so a new item may be offered in every cycle. The item is held in the
// input register, with the whole round computed behind it, and is then loaded into the
// result register. The result is therefore shown on out_low/out_high, with out_valid
// high for exactly one cycle, in the cycle after the next clock edge. The receiver
// cannot stall the block and must take each result in the cycle in which it is shown.
// Results leave in the order in which items arrived.
module aes_encrypt_round (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0]  in_state_low,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0]  in_state_high,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0]  in_round_key_low,
  input  wire logic [aes_rnd_pkg::HALF_W-1:0]  in_round_key_high,
  output logic                                 out_valid,
  output logic      [aes_rnd_pkg::HALF_W-1:0]  out_low,
  output logic      [aes_rnd_pkg::HALF_W-1:0]  out_high
);
  import aes_rnd_pkg::*;

  logic              accept;
  logic              in_valid_r;
  logic [HALF_W-1:0] state_low_r;
  logic [HALF_W-1:0] state_high_r;
  logic [HALF_W-1:0] key_low_r;
  logic [HALF_W-1:0] key_high_r;
  logic [HALF_W-1:0] res_low;
  logic [HALF_W-1:0] res_high;
  logic              out_valid_r;
  logic [HALF_W-1:0] out_low_r;
  logic [HALF_W-1:0] out_high_r;

  // The round is computed combinationally between the registers, so the block is always ready.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Input register: control is reset, payload is loaded on each transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      state_low_r  <= in_state_low;
      state_high_r <= in_state_high;
      key_low_r    <= in_round_key_low;
      key_high_r   <= in_round_key_high;
    end
  end

  // Round logic between the two registers.
  aes_rnd_core u_core (
    .state_low  (state_low_r),
    .state_high (state_high_r),
    .key_low    (key_low_r),
    .key_high   (key_high_r),
    .res_low    (res_low),
    .res_high   (res_high)
  );

  // Result register: the strobe lasts one cycle per item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_low_r  <= res_low;
      out_high_r <= res_high;
    end
  end

  assign out_valid = out_valid_r;
  assign out_low   = out_low_r;
  assign out_high  = out_high_r;

  // Every accepted item yields a result, through the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted item produced no result");

  // No result is shown without a matching item taken before it.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ##1 !out_valid)
    else $error("result shown without a matching transfer");

  // The block never holds off the sender.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // A zero state with a zero key gives the substituted value 0x63 in every byte.
  a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(accept && in_state_low == '0 && in_state_high == '0
       && in_round_key_low == '0 && in_round_key_high == '0, 2))
    |-> (out_low == {8{SBOX[0]}} && out_high == {8{SBOX[0]}}))
    else $error("round of zero state and zero key is wrong");

endmodule

`default_nettype wire

// ----- dv/tb_aes_encrypt_round.sv -----
// Self-checking testbench for aes_encrypt_round: one AES encryption round per transfer.
// Holds its own S-box, round predictor, driver and result monitor.
// Depends on aes_rnd_pkg for the half-word width and on the aes_encrypt_round RTL.
`default_nettype none

module tb_aes_encrypt_round;
  import aes_rnd_pkg::*;

  localparam int HW = HALF_W;

  // Forward S-box, entry 0 in the top byte.
  localparam logic [2047:0] SBOX_BYTES = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  typedef struct packed {
    logic [HW-1:0] s_lo;
    logic [HW-1:0] s_hi;
    logic [HW-1:0] k_lo;
    logic [HW-1:0] k_hi;
  } round_in_t;

  typedef struct packed {
    logic [HW-1:0] lo;
    logic [HW-1:0] hi;
  } round_out_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic [HW-1:0] in_state_low = '0;
  logic [HW-1:0] in_state_high = '0;
  logic [HW-1:0] in_round_key_low = '0;
  logic [HW-1:0] in_round_key_high = '0;
  logic          busy;
  logic          out_valid;
  logic [HW-1:0] out_low;
  logic [HW-1:0] out_high;

  round_in_t  round_inputs_q [$];
  round_out_t expected_rounds [$];
  logic       took = 1'b0;
  int         gap_left = 0;
  int         n_offered = 0;
  logic       drain_hold = 1'b0;
  int         fail_count = 0;

  aes_encrypt_round u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_state_low      (in_state_low),
    .in_state_high     (in_state_high),
    .in_round_key_low  (in_round_key_low),
    .in_round_key_high (in_round_key_high),
    .out_valid         (out_valid),
    .out_low           (out_low),
    .out_high          (out_high)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] sbox_lookup(input logic [7:0] b);
    return SBOX_BYTES[8*(255 - b) +: 8];
  endfunction

  // Multiply by x in GF(2^8), folding the carry back with the AES polynomial.
  function automatic logic [7:0] gf_mul_x(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Full round: SubBytes, ShiftRows, MixColumns and AddRoundKey, byte i = 4*column + row.
  function automatic round_out_t aes_round_predict(input round_in_t it);
    logic [127:0] st;
    logic [127:0] rk;
    logic [127:0] res;
    logic [7:0]   sb [16];
    logic [7:0]   a [4];
    logic [7:0]   col_xor;
    round_out_t   o;
    st = {it.s_hi, it.s_lo};
    rk = {it.k_hi, it.k_lo};
    for (int i = 0; i < 16; i++) sb[i] = sbox_lookup(st[8*i +: 8]);
    for (int c = 0; c < 4; c++) begin
      // Row r of the shifted state takes its byte from column (c + r) mod 4.
      for (int r = 0; r < 4; r++) a[r] = sb[4*((c + r) % 4) + r];
      col_xor = a[0] ^ a[1] ^ a[2] ^ a[3];
      for (int r = 0; r < 4; r++) begin
        res[8*(4*c + r) +: 8] = a[r] ^ col_xor ^ gf_mul_x(a[r] ^ a[(r + 1) % 4])
                                ^ rk[8*(4*c + r) +: 8];
      end
    end
    o.lo = res[63:0];
    o.hi = res[127:64];
    return o;
  endfunction

  function automatic logic [HW-1:0] rand_half();
    int r;
    r = $urandom_range(15);
    if (r == 0) return '1;
    if (r == 1) return '0;
    if (r == 2) return 64'h1 << $urandom_range(63);
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back or short gaps, a few long ones, and whole stretches with none.
  function automatic int pick_gap(input int n);
    int r;
    if ((n % 200) < 40) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic add_round(input logic [HW-1:0] s_lo, input logic [HW-1:0] s_hi,
                           input logic [HW-1:0] k_lo, input logic [HW-1:0] k_hi);
    round_in_t it;
    it.s_lo = s_lo;
    it.s_hi = s_hi;
    it.k_lo = k_lo;
    it.k_hi = k_hi;
    round_inputs_q.push_back(it);
  endtask

  // Driver: offers the next round at the falling edge and holds it until the transfer.
  always @(negedge clk) begin
    round_in_t nxt;
    logic      offer;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !took)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (drain_hold && expected_rounds.size() != 0) begin
        offer = 1'b0;
      end else if (round_inputs_q.size() != 0) begin
        nxt = round_inputs_q.pop_front();
        offer = 1'b1;
        n_offered = n_offered + 1;
        gap_left = pick_gap(n_offered);
        // Now and then let the block drain completely before the next transfer.
        drain_hold = (n_offered % 97 == 0);
      end
      start <= offer;
      if (offer) begin
        in_state_low      <= nxt.s_lo;
        in_state_high     <= nxt.s_hi;
        in_round_key_low  <= nxt.k_lo;
        in_round_key_high <= nxt.k_hi;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction and predicts accepted rounds.
  always @(posedge clk) begin
    round_out_t exp_r;
    round_in_t  acc;
    if (!rst_n) begin
      took = 1'b0;
    end else begin
      took = start && !busy;
      if (out_valid) begin
        if (expected_rounds.size() == 0) begin
          $error("result with nothing expected: out_low %h out_high %h", out_low, out_high);
          fail_count++;
        end else begin
          exp_r = expected_rounds.pop_front();
          if (out_low !== exp_r.lo) begin
            $error("out_low mismatch: expected %h, got %h", exp_r.lo, out_low);
            fail_count++;
          end
          if (out_high !== exp_r.hi) begin
            $error("out_high mismatch: expected %h, got %h", exp_r.hi, out_high);
            fail_count++;
          end
        end
      end
      if (took) begin
        acc.s_lo = in_state_low;
        acc.s_hi = in_state_high;
        acc.k_lo = in_round_key_low;
        acc.k_hi = in_round_key_high;
        expected_rounds.push_back(aes_round_predict(acc));
      end
    end
  end

  // Main sequence: directed rounds, random rounds, then drain and report.
  initial begin
    logic [127:0] sweep;
    // Extremes of state and key.
    add_round('0, '0, '0, '0);
    add_round('1, '1, '0, '0);
    add_round('0, '0, '1, '1);
    add_round('1, '1, '1, '1);
    add_round({32{2'b10}}, {32{2'b01}}, {32{2'b01}}, {32{2'b10}});
    // The first round of the standard's worked cipher example.
    add_round(64'h2be2f4a0_bee33d19, 64'h0848f8e9_2a8dc69a,
              64'hb12c5488_17fefaa0, 64'h05766c2a_3939a323);
    // Every byte value through the S-box, spread over the byte positions across the sweep.
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 16; i++) sweep[8*i +: 8] = 8'((16*k + 5*i) % 256);
      add_round(sweep[63:0], sweep[127:64], rand_half(), rand_half());
    end
    for (int n = 0; n < 1000; n++) add_round(rand_half(), rand_half(), rand_half(), rand_half());

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every round offered and taken, then every result back.
    do @(posedge clk); while (round_inputs_q.size() != 0 || start);
    do @(negedge clk); while (expected_rounds.size() != 0);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && expected_rounds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #(20 * 300000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
